// ===== sv/ntc_pkg.sv =====
// ----------------------------------------------------------------------------
// ntc_pkg
// shared types, codes and constants of the ntc thermistor temperature block
// ----------------------------------------------------------------------------
package ntc_pkg;

    // default converter width
    localparam int ADC_BITS_DEF = 12;

    // q16.16 magnitude of x and x*x (1.0 included)
    localparam int X_W = 17;
    // horner accumulator width
    localparam int Y_W = 20;
    // series term count register width and longest series
    localparam int TERMS_W   = 5;
    localparam int TERMS_MAX = 31;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_ZERO = 2'd1,
        ST_FULL = 2'd2,
        ST_SAT  = 2'd3
    } t_status;

    // register indexes of the configuration port
    typedef enum logic [2:0] {
        CFG_BETA   = 3'd0,
        CFG_R25    = 3'd1,
        CFG_RDIV   = 3'd2,
        CFG_OFFSET = 3'd3,
        CFG_TERMS  = 3'd4
    } t_cfg_index;

    // round(65536 / n) for odd n = 2*i + 1
    localparam logic [X_W-1:0] RECIP_TAB [TERMS_MAX+1] = '{
        17'd65536, 17'd21845, 17'd13107, 17'd9362,  17'd7282,  17'd5958,
        17'd5041,  17'd4369,  17'd3855,  17'd3449,  17'd3121,  17'd2849,
        17'd2621,  17'd2427,  17'd2260,  17'd2114,  17'd1986,  17'd1872,
        17'd1771,  17'd1680,  17'd1598,  17'd1524,  17'd1456,  17'd1394,
        17'd1337,  17'd1285,  17'd1237,  17'd1192,  17'd1150,  17'd1111,
        17'd1074,  17'd1040
    };

    // round(b * 6553600 / 29815) = 219*b + floor((24115*b + 14907) / 29815)
    localparam logic [7:0]  BQ_INT   = 8'd219;
    localparam logic [15:0] BQ_MUL   = 16'd24115;
    localparam logic [14:0] BQ_ADD   = 15'd14907;
    localparam logic [32:0] BQ_RECIP = 33'd4720358490;   // ceil(2^47 / 29815)
    localparam int          BQ_SHIFT = 47;

    // 273.15 in q8.8
    localparam logic [16:0] ZERO_C_Q8 = 17'd69926;

    // reset values of the registers
    localparam logic [15:0]        BETA_RST   = 16'd3950;
    localparam logic [15:0]        R25_RST    = 16'd2560;
    localparam logic [15:0]        RDIV_RST   = 16'd2560;
    localparam logic [15:0]        OFFSET_RST = 16'hFD00;
    localparam logic [TERMS_W-1:0] TERMS_RST  = 5'd10;

endpackage

// ===== sv/ntc_div_cell.sv =====
// ----------------------------------------------------------------------------
// ntc_div_cell
// one restoring division step: one quotient bit per cell
// ----------------------------------------------------------------------------
module ntc_div_cell #(
    parameter int DEN_W  = 29,
    parameter int QUO_W  = 17,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [DEN_W-1:0]  i_rem,
    input  logic [QUO_W-1:0]  i_quo,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [DEN_W-1:0]  o_rem,
    output logic [QUO_W-1:0]  o_quo,
    output logic [DEN_W-1:0]  o_den,
    output logic [SIDE_W-1:0] o_side
);

    logic              r_valid;
    logic [DEN_W-1:0]  r_rem, n_rem;
    logic [QUO_W-1:0]  r_quo, n_quo;
    logic [DEN_W-1:0]  r_den;
    logic [SIDE_W-1:0] r_side;
    logic [DEN_W:0]    w_trial;
    logic              w_ge;

    // shift in the next numerator bit, quotient bit shifts in at the bottom
    always_comb begin
        w_trial = {i_rem, i_quo[QUO_W-1]};
        w_ge    = (w_trial >= {1'b0, i_den});
        n_rem   = w_ge ? DEN_W'(w_trial - {1'b0, i_den}) : DEN_W'(w_trial);
        n_quo   = {i_quo[QUO_W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_quo  <= n_quo;
            r_den  <= i_den;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_quo   = r_quo;
    assign o_den   = r_den;
    assign o_side  = r_side;

endmodule

// ===== sv/ntc_div_chain.sv =====
// ----------------------------------------------------------------------------
// ntc_div_chain
// row of division cells, one quotient bit per cycle per cell while i_en is high
// ----------------------------------------------------------------------------
module ntc_div_chain #(
    parameter int DEN_W  = 29,
    parameter int QUO_W  = 17,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [DEN_W-1:0]  i_rem,
    input  logic [QUO_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [QUO_W-1:0]  o_quo,
    output logic [SIDE_W-1:0] o_side
);

    logic              w_v    [QUO_W+1];
    logic [DEN_W-1:0]  w_rem  [QUO_W+1];
    logic [QUO_W-1:0]  w_quo  [QUO_W+1];
    logic [DEN_W-1:0]  w_den  [QUO_W+1];
    logic [SIDE_W-1:0] w_side [QUO_W+1];

    assign w_v[0]    = i_valid;
    assign w_rem[0]  = i_rem;
    assign w_quo[0]  = i_num;
    assign w_den[0]  = i_den;
    assign w_side[0] = i_side;

    for (genvar g = 0; g < QUO_W; g++) begin : g_cell
        ntc_div_cell #(
            .DEN_W (DEN_W),
            .QUO_W (QUO_W),
            .SIDE_W(SIDE_W)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (i_en),
            .i_valid(w_v[g]),
            .i_rem  (w_rem[g]),
            .i_quo  (w_quo[g]),
            .i_den  (w_den[g]),
            .i_side (w_side[g]),
            .o_valid(w_v[g+1]),
            .o_rem  (w_rem[g+1]),
            .o_quo  (w_quo[g+1]),
            .o_den  (w_den[g+1]),
            .o_side (w_side[g+1])
        );
    end

    assign o_valid = w_v[QUO_W];
    assign o_quo   = w_quo[QUO_W];
    assign o_side  = w_side[QUO_W];

endmodule

// ===== sv/ntc_horner_cell.sv =====
// ----------------------------------------------------------------------------
// ntc_horner_cell
// one horner step of the atanh log series: y = 1/(2k-1) + x*x*y
// ----------------------------------------------------------------------------
module ntc_horner_cell
    import ntc_pkg::*;
#(
    parameter int TERM   = 1,
    parameter int SIDE_W = 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [TERMS_W-1:0] i_terms,
    input  logic [X_W-1:0]     i_xx,
    input  logic [Y_W-1:0]     i_y,
    input  logic [SIDE_W-1:0]  i_side,
    output logic               o_valid,
    output logic [X_W-1:0]     o_xx,
    output logic [Y_W-1:0]     o_y,
    output logic [SIDE_W-1:0]  o_side
);

    localparam logic [X_W-1:0]     RECIP     = RECIP_TAB[TERM-1];
    localparam logic [TERMS_W-1:0] TERM_CODE = TERMS_W'(TERM);

    logic                 r_valid;
    logic [X_W-1:0]       r_xx;
    logic [Y_W-1:0]       r_y, n_y;
    logic [SIDE_W-1:0]    r_side;
    logic [X_W+Y_W-1:0]   w_prod;
    logic [Y_W:0]         w_rnd;

    // cells above the programmed term count pass y through
    always_comb begin
        w_prod = (X_W+Y_W)'(i_xx) * (X_W+Y_W)'(i_y);
        w_rnd  = (Y_W+1)'((w_prod + (X_W+Y_W)'(32768)) >> 16);
        n_y    = (i_terms >= TERM_CODE) ? Y_W'(w_rnd + (Y_W+1)'(RECIP)) : i_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xx   <= i_xx;
            r_y    <= n_y;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_xx    = r_xx;
    assign o_y     = r_y;
    assign o_side  = r_side;

endmodule

// ===== sv/ntc_adc_to_temperature.sv =====
// ----------------------------------------------------------------------------
// ntc_adc_to_temperature
// thermistor divider adc code to signed q8.8 degrees c by the beta equation
// ----------------------------------------------------------------------------
// throughput: one item per cycle while o_stall is low, set by the fully pipelined
//   divider and horner cell rows (17 + 31 + 40 cells, each one step per cycle)
// a two-entry output (register plus skid) decouples o_stall from i_stall
// reset (synchronous, active low) clears all valid bits and loads the
//   configuration registers with their defaults
// ----------------------------------------------------------------------------
module ntc_adc_to_temperature
    import ntc_pkg::*;
#(
    parameter int ADC_BITS = ADC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // item input
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [ADC_BITS-1:0] i_adc_code,
    // result output
    output logic                o_valid,
    input  logic                i_stall,
    output logic signed [15:0]  o_temperature,
    output logic [1:0]          o_status,
    // configuration writes
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data
);

    // widths of the resistance and first division path
    localparam int PROD_W = ADC_BITS + 16;       // code * resistance
    localparam int DEN_W  = ADC_BITS + 17;       // sum of both legs
    localparam int N1_W   = PROD_W + 17;         // |a-b| * 2^16 + den/2
    localparam int Q1_W   = X_W;                 // |x| in q16.16, up to 1.0
    localparam int SIDE1_W = 4;                  // status, den zero, sign
    localparam int SIDEH_W = 3 + X_W;            // status, sign, |x|
    localparam int P_W     = X_W + Y_W;          // |x| * y
    localparam int D_W     = 26;                 // signed log plus b/298.15
    localparam int D2_W    = 25;                 // positive divisor
    localparam int Q2_W    = 16 + D2_W - 1;      // b * 2^24 + d/2
    localparam int SIDE2_W = 3;                  // status, divisor positive
    localparam int T_W     = Q2_W + 3;           // kelvin to celsius sum
    localparam logic [ADC_BITS-1:0] FS = '1;

    // ------------------------------------------------------------------
    // configuration registers, to be written only while idle; the block does not enforce it
    // ------------------------------------------------------------------
    logic [15:0]        r_beta;
    logic [15:0]        r_r25;
    logic [15:0]        r_rdiv;
    logic [15:0]        r_offset;
    logic [TERMS_W-1:0] r_terms;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beta   <= BETA_RST;
            r_r25    <= R25_RST;
            r_rdiv   <= RDIV_RST;
            r_offset <= OFFSET_RST;
            r_terms  <= TERMS_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_BETA:   r_beta   <= i_cfg_data;
                CFG_R25:    r_r25    <= i_cfg_data;
                CFG_RDIV:   r_rdiv   <= i_cfg_data;
                CFG_OFFSET: r_offset <= i_cfg_data;
                CFG_TERMS:  r_terms  <= i_cfg_data[TERMS_W-1:0];
                default:    ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // b / 298.15 in q16.16, follows the beta register through r_bq_m, r_bq_p and r_bq
    // reciprocal multiply is exact over the whole 16-bit range
    // ------------------------------------------------------------------
    logic [31:0] r_bq_m;
    logic [63:0] r_bq_p;
    logic [23:0] r_bq;

    always_ff @(posedge i_clk) begin
        r_bq_m <= 32'(r_beta) * 32'(BQ_MUL) + 32'(BQ_ADD);
        r_bq_p <= {32'b0, r_bq_m} * {31'b0, BQ_RECIP};
        r_bq   <= 24'(r_beta) * 24'(BQ_INT) + 24'(r_bq_p >> BQ_SHIFT);
    end

    // ------------------------------------------------------------------
    // pipeline enable: the whole row freezes only while the skid is full
    // ------------------------------------------------------------------
    logic r_skid_valid;
    logic w_en;

    assign w_en    = !r_skid_valid;
    assign o_stall = r_skid_valid;

    // stage 0: capture the code and flag the rails
    logic                r_s0_valid;
    logic [ADC_BITS-1:0] r_s0_c;
    t_status             r_s0_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (w_en) begin
            r_s0_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0_c <= i_adc_code;
            if (i_adc_code == '0) begin
                r_s0_st <= ST_ZERO;
            end else if (i_adc_code == FS) begin
                r_s0_st <= ST_FULL;
            end else begin
                r_s0_st <= ST_OK;
            end
        end
    end

    // stage 1: both legs of the divider, c*rdiv and (fs-c)*r25
    logic              r_s1_valid;
    logic [PROD_W-1:0] r_s1_a;
    logic [PROD_W-1:0] r_s1_b;
    t_status           r_s1_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_en) begin
            r_s1_valid <= r_s0_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_a  <= PROD_W'(r_s0_c) * PROD_W'(r_rdiv);
            r_s1_b  <= PROD_W'(FS - r_s0_c) * PROD_W'(r_r25);
            r_s1_st <= r_s0_st;
        end
    end

    // stage 2: x = (a-b)/(a+b) set up as magnitude over sum, rounded
    logic               r_s2_valid;
    logic [DEN_W-1:0]   r_s2_rem;
    logic [Q1_W-1:0]    r_s2_num;
    logic [DEN_W-1:0]   r_s2_den;
    logic [SIDE1_W-1:0] r_s2_side;
    logic [DEN_W-1:0]   w_s2_den;
    logic               w_s2_neg;
    logic [PROD_W-1:0]  w_s2_mag;
    logic [N1_W-1:0]    w_s2_n1;

    always_comb begin
        w_s2_den = DEN_W'(r_s1_a) + DEN_W'(r_s1_b);
        w_s2_neg = (r_s1_b > r_s1_a);
        w_s2_mag = w_s2_neg ? (r_s1_b - r_s1_a) : (r_s1_a - r_s1_b);
        w_s2_n1  = {1'b0, w_s2_mag, 16'b0} + N1_W'(w_s2_den >> 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_en) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    // upper numerator bits are below the divisor, so 17 steps suffice
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_rem  <= DEN_W'(w_s2_n1 >> Q1_W);
            r_s2_num  <= w_s2_n1[Q1_W-1:0];
            r_s2_den  <= w_s2_den;
            r_s2_side <= {r_s1_st, (w_s2_den == '0), w_s2_neg};
        end
    end

    // first divider row: |x| in q16.16
    logic               w_d1_valid;
    logic [Q1_W-1:0]    w_d1_quo;
    logic [SIDE1_W-1:0] w_d1_side;

    ntc_div_chain #(
        .DEN_W (DEN_W),
        .QUO_W (Q1_W),
        .SIDE_W(SIDE1_W)
    ) u_div_x (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_valid(r_s2_valid),
        .i_rem  (r_s2_rem),
        .i_num  (r_s2_num),
        .i_den  (r_s2_den),
        .i_side (r_s2_side),
        .o_valid(w_d1_valid),
        .o_quo  (w_d1_quo),
        .o_side (w_d1_side)
    );

    // stage 3: both resistances zero forces x to 0, then square |x|
    logic              r_s3_valid;
    logic [2*X_W-1:0]  r_s3_sq;
    logic [X_W-1:0]    r_s3_ax;
    logic              r_s3_neg;
    logic [1:0]        r_s3_st;
    logic [X_W-1:0]    w_s3_ax;

    assign w_s3_ax = w_d1_side[1] ? '0 : w_d1_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (w_en) begin
            r_s3_valid <= w_d1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s3_sq  <= (2*X_W)'(w_s3_ax) * (2*X_W)'(w_s3_ax);
            r_s3_ax  <= w_s3_ax;
            r_s3_neg <= w_d1_side[0];
            r_s3_st  <= w_d1_side[3:2];
        end
    end

    // stage 4: round x*x and seed horner with 1/(2n+1)
    logic               r_s4_valid;
    logic [X_W-1:0]     r_s4_xx;
    logic [Y_W-1:0]     r_s4_y;
    logic [SIDEH_W-1:0] r_s4_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
        end else if (w_en) begin
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s4_xx   <= X_W'((r_s3_sq + (2*X_W)'(32768)) >> 16);
            r_s4_y    <= Y_W'(RECIP_TAB[r_terms]);
            r_s4_side <= {r_s3_st, r_s3_neg, r_s3_ax};
        end
    end

    // horner row: term 31 first, term 1 last, idle cells pass y through
    logic               w_h_v    [TERMS_MAX+1];
    logic [X_W-1:0]     w_h_xx   [TERMS_MAX+1];
    logic [Y_W-1:0]     w_h_y    [TERMS_MAX+1];
    logic [SIDEH_W-1:0] w_h_side [TERMS_MAX+1];

    assign w_h_v[0]    = r_s4_valid;
    assign w_h_xx[0]   = r_s4_xx;
    assign w_h_y[0]    = r_s4_y;
    assign w_h_side[0] = r_s4_side;

    for (genvar g = 0; g < TERMS_MAX; g++) begin : g_horner
        ntc_horner_cell #(
            .TERM  (TERMS_MAX - g),
            .SIDE_W(SIDEH_W)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (w_en),
            .i_valid(w_h_v[g]),
            .i_terms(r_terms),
            .i_xx   (w_h_xx[g]),
            .i_y    (w_h_y[g]),
            .i_side (w_h_side[g]),
            .o_valid(w_h_v[g+1]),
            .o_xx   (w_h_xx[g+1]),
            .o_y    (w_h_y[g+1]),
            .o_side (w_h_side[g+1])
        );
    end

    // stage 5: |x| * y
    logic           r_s5_valid;
    logic [P_W-1:0] r_s5_p;
    logic           r_s5_neg;
    logic [1:0]     r_s5_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_valid <= 1'b0;
        end else if (w_en) begin
            r_s5_valid <= w_h_v[TERMS_MAX];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s5_p   <= P_W'(w_h_side[TERMS_MAX][X_W-1:0]) * P_W'(w_h_y[TERMS_MAX]);
            r_s5_neg <= w_h_side[TERMS_MAX][X_W];
            r_s5_st  <= w_h_side[TERMS_MAX][X_W+2:X_W+1];
        end
    end

    // stage 6: ln = 2*x*y rounded, d = ln + b/298.15, set up b*2^24 + d/2
    logic                r_s6_valid;
    logic [Q2_W-1:0]     r_s6_num;
    logic [D2_W-1:0]     r_s6_den;
    logic [SIDE2_W-1:0]  r_s6_side;
    logic [21:0]         w_s6_lnmag;
    logic signed [D_W-1:0] w_s6_ln;
    logic signed [D_W-1:0] w_s6_d;
    logic                w_s6_pos;

    always_comb begin
        w_s6_lnmag = 22'(({r_s5_p, 1'b0} + (P_W+1)'(32768)) >> 16);
        w_s6_ln    = r_s5_neg ? -$signed(D_W'(w_s6_lnmag)) : $signed(D_W'(w_s6_lnmag));
        w_s6_d     = w_s6_ln + $signed(D_W'(r_bq));
        w_s6_pos   = !w_s6_d[D_W-1] && (w_s6_d != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_valid <= 1'b0;
        end else if (w_en) begin
            r_s6_valid <= r_s5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s6_num  <= {r_beta, w_s6_d[D2_W-1:1]};
            r_s6_den  <= w_s6_d[D2_W-1:0];
            r_s6_side <= {r_s5_st, w_s6_pos};
        end
    end

    // second divider row: kelvin in q8.8
    logic               w_d2_valid;
    logic [Q2_W-1:0]    w_d2_quo;
    logic [SIDE2_W-1:0] w_d2_side;

    ntc_div_chain #(
        .DEN_W (D2_W),
        .QUO_W (Q2_W),
        .SIDE_W(SIDE2_W)
    ) u_div_k (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_valid(r_s6_valid),
        .i_rem  ('0),
        .i_num  (r_s6_num),
        .i_den  (r_s6_den),
        .i_side (r_s6_side),
        .o_valid(w_d2_valid),
        .o_quo  (w_d2_quo),
        .o_side (w_d2_side)
    );

    // stage 7: to celsius, add offset, saturate, merge the error cases
    logic                  r_s7_valid;
    logic signed [15:0]    r_s7_t;
    t_status               r_s7_st;
    logic signed [T_W-1:0] w_s7_t;
    t_status               w_s7_code;

    always_comb begin
        w_s7_t    = $signed({3'b0, w_d2_quo}) - $signed(T_W'(ZERO_C_Q8))
                  + T_W'($signed(r_offset));
        w_s7_code = t_status'(w_d2_side[2:1]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s7_valid <= 1'b0;
        end else if (w_en) begin
            r_s7_valid <= w_d2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w_s7_code != ST_OK) begin
                // rail codes give no temperature
                r_s7_t  <= 16'sd0;
                r_s7_st <= w_s7_code;
            end else if (!w_d2_side[0]) begin
                // non-positive denominator reads as extremely hot
                r_s7_t  <= 16'sd32767;
                r_s7_st <= ST_SAT;
            end else if (w_s7_t > T_W'(32767)) begin
                r_s7_t  <= 16'sd32767;
                r_s7_st <= ST_SAT;
            end else if (w_s7_t < -T_W'(32768)) begin
                r_s7_t  <= -16'sd32768;
                r_s7_st <= ST_SAT;
            end else begin
                r_s7_t  <= w_s7_t[15:0];
                r_s7_st <= ST_OK;
            end
        end
    end

    // ------------------------------------------------------------------
    // output register plus skid entry
    // an item leaves the last stage whenever the row advances
    // ------------------------------------------------------------------
    logic               r_out_valid;
    logic signed [15:0] r_out_t;
    t_status            r_out_st;
    logic signed [15:0] r_skid_t;
    t_status            r_skid_st;
    logic               w_move;
    logic               w_out_free;

    assign w_move     = w_en && r_s7_valid;
    assign w_out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= w_move;
            end
        end else if (w_move) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            if (r_skid_valid) begin
                r_out_t  <= r_skid_t;
                r_out_st <= r_skid_st;
            end else begin
                r_out_t  <= r_s7_t;
                r_out_st <= r_s7_st;
            end
        end else if (w_move) begin
            r_skid_t  <= r_s7_t;
            r_skid_st <= r_s7_st;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_temperature = r_out_t;
    assign o_status      = r_out_st;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // the skid only holds an item behind a held output item
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds an item with the output register empty");

    // the skid fills only when the output was held by the receiver
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && i_stall))
        else $error("skid filled while the output was free");

    // rail codes report a zero temperature
    a_rail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_ZERO || o_status == ST_FULL)) |-> (o_temperature == 16'sd0))
        else $error("rail code with nonzero temperature");

endmodule

// ===== bench/tb_ntc_adc_to_temperature.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ntc_adc_to_temperature
// drives adc codes through the thermistor block under changing register
// settings and idling patterns, predicts every temperature and status in
// fixed point and compares them in order
// ----------------------------------------------------------------------------
module tb_ntc_adc_to_temperature;
    import ntc_pkg::*;

    localparam int ADC_W    = 12;
    localparam int FULL     = (1 << ADC_W) - 1;
    localparam int LATENCY  = 97;
    localparam int WD_LIMIT = 20000;

    typedef struct packed {
        logic signed [15:0] temperature;
        logic [1:0]         status;
    } t_reading;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [ADC_W-1:0]   i_adc_code = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [15:0] o_temperature;
    logic [1:0]         o_status;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index = '0;
    logic [15:0]        i_cfg_data = '0;

    ntc_adc_to_temperature #(.ADC_BITS(ADC_W)) uut (.*);

    always #6 i_clk = ~i_clk;

    // predictor copy of the registers
    logic [15:0] beta_q, r25_q, rdiv_q, offset_q;
    logic [4:0]  terms_q;

    logic [ADC_W-1:0] code_queue[$];
    t_reading         reading_queue[$];

    int  errors = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  hold_recv = 1'b0;
    bit  cfg_busy = 1'b0;
    int  quiet_cycles = 0;

    // rounded division, half away from zero
    function automatic longint div_round(longint num, longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = (mag + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic t_reading convert_code(logic [ADC_W-1:0] code);
        t_reading r;
        longint a, b, den, x, ax, xx, y, nk, lnq, bq, d, t, off;
        r.status = ST_OK;
        if (code == 0 || code == FULL) begin
            r.temperature = '0;
            r.status = (code == 0) ? ST_ZERO : ST_FULL;
            return r;
        end
        a = longint'(code) * rdiv_q;
        b = longint'(FULL - code) * r25_q;
        den = a + b;
        x = 0;
        if (den != 0)
            x = div_round((a - b) * 65536, den);
        ax = (x < 0) ? -x : x;
        xx = (ax * ax + 32768) >>> 16;
        // horner over the odd reciprocals, innermost term first
        nk = 2 * terms_q + 1;
        y = (65536 + nk / 2) / nk;
        for (int k = terms_q; k > 0; k--) begin
            nk -= 2;
            y = (65536 + nk / 2) / nk + ((xx * y + 32768) >>> 16);
        end
        lnq = div_round(2 * x * y, 65536);
        bq = div_round(longint'(beta_q) * 6553600, 29815);
        d = lnq + bq;
        if (d <= 0) begin
            t = 32767;
            r.status = ST_SAT;
        end else begin
            off = longint'($signed(offset_q));
            t = div_round(longint'(beta_q) * 16777216, d) - 69926 + off;
            if (t > 32767) begin
                t = 32767;
                r.status = ST_SAT;
            end else if (t < -32768) begin
                t = -32768;
                r.status = ST_SAT;
            end
        end
        r.temperature = t[15:0];
        return r;
    endfunction

    // driver: offers the head of the code queue, idles at random
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                reading_queue.push_back(convert_code(i_adc_code));
                void'(code_queue.pop_front());
            end
            if ((i_valid && o_stall) ||
                (code_queue.size() != 0 &&
                 $urandom_range(99) >= send_idle_pct)) begin
                i_valid <= 1'b1;
                i_adc_code <= (i_valid && o_stall) ? i_adc_code : code_queue[0];
            end else begin
                i_valid <= 1'b0;
            end
            i_stall <= hold_recv || ($urandom_range(99) < recv_stall_pct);
        end
    end

    // monitor: checks each accepted reading against the oldest prediction
    always @(posedge i_clk) begin
        t_reading want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (reading_queue.size() == 0) begin
                $display("%0t unexpected reading temp %0d status %0d",
                         $time, o_temperature, o_status);
                errors++;
            end else begin
                want = reading_queue.pop_front();
                if (want.temperature !== o_temperature) begin
                    $display("%0t temperature expected %0d actual %0d",
                             $time, want.temperature, o_temperature);
                    errors++;
                end
                if (want.status !== o_status) begin
                    $display("%0t status expected %0d actual %0d",
                             $time, want.status, o_status);
                    errors++;
                end
            end
        end
    end

    // watchdog: cycles with no item, reading or register write accepted
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) ||
            (i_cfg_valid && o_cfg_ready) || hold_recv || cfg_busy)
            quiet_cycles <= 0;
        else if (code_queue.size() != 0 || reading_queue.size() != 0)
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WD_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic write_reg(t_cfg_index idx, logic [15:0] value);
        cfg_busy = 1'b1;
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_BETA:   beta_q = value;
            CFG_R25:    r25_q = value;
            CFG_RDIV:   rdiv_q = value;
            CFG_OFFSET: offset_q = value;
            default:    terms_q = value[4:0];
        endcase
        cfg_busy = 1'b0;
    endtask

    task automatic drain_all();
        while (code_queue.size() != 0 || reading_queue.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    // random codes, with a share near the rails and the extremes
    task automatic queue_codes(int n);
        int sel;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(9);
            if (sel == 0)
                code_queue.push_back(ADC_W'($urandom_range(3)));
            else if (sel == 1)
                code_queue.push_back(ADC_W'(FULL - $urandom_range(3)));
            else
                code_queue.push_back(ADC_W'($urandom));
        end
    endtask

    task automatic run_phase(int n, int idle, int stall);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        queue_codes(n);
        drain_all();
    endtask

    initial begin
        beta_q = BETA_RST;
        r25_q = R25_RST;
        rdiv_q = RDIV_RST;
        offset_q = OFFSET_RST;
        terms_q = TERMS_RST;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: rails, neighbors of the rails, midscale, alternating bit patterns
        code_queue.push_back(ADC_W'(0));
        code_queue.push_back(ADC_W'(FULL));
        code_queue.push_back(ADC_W'(1));
        code_queue.push_back(ADC_W'(FULL - 1));
        code_queue.push_back(ADC_W'(2048));
        code_queue.push_back(ADC_W'(2047));
        code_queue.push_back(12'hAAA);
        code_queue.push_back(12'h555);
        drain_all();

        // extremes of the registers: huge beta and short series
        write_reg(CFG_BETA, 16'd65535);
        write_reg(CFG_R25, 16'd1);
        write_reg(CFG_RDIV, 16'd65535);
        write_reg(CFG_OFFSET, 16'h7FFF);
        write_reg(CFG_TERMS, 16'd0);
        code_queue.push_back(ADC_W'(1));
        code_queue.push_back(ADC_W'(FULL - 1));
        code_queue.push_back(ADC_W'(2048));
        drain_all();
        // tiny beta, negative offset, longest series: saturation and d <= 0
        write_reg(CFG_BETA, 16'd1);
        write_reg(CFG_R25, 16'd65535);
        write_reg(CFG_RDIV, 16'd1);
        write_reg(CFG_OFFSET, 16'h8000);
        write_reg(CFG_TERMS, 16'd31);
        code_queue.push_back(ADC_W'(1));
        code_queue.push_back(ADC_W'(FULL - 1));
        code_queue.push_back(ADC_W'(100));
        drain_all();

        // back to defaults but 16 terms, random with and without sender idles
        write_reg(CFG_BETA, BETA_RST);
        write_reg(CFG_R25, R25_RST);
        write_reg(CFG_RDIV, RDIV_RST);
        write_reg(CFG_OFFSET, OFFSET_RST);
        write_reg(CFG_TERMS, 16'd16);
        run_phase(80, 0, 0);
        run_phase(60, 77, 0);

        // long receiver hold-off while items keep coming: pipeline fills up
        send_idle_pct = 0;
        recv_stall_pct = 0;
        queue_codes(150);
        hold_recv = 1'b1;
        repeat (300) @(posedge i_clk);
        hold_recv = 1'b0;
        drain_all();

        write_reg(CFG_TERMS, 16'd1);
        write_reg(CFG_OFFSET, 16'($urandom));
        run_phase(60, 0, 77);
        write_reg(CFG_BETA, 16'($urandom_range(65535, 1)));
        write_reg(CFG_R25, 16'($urandom_range(65535, 1)));
        write_reg(CFG_RDIV, 16'($urandom_range(65535, 1)));
        write_reg(CFG_TERMS, 16'($urandom_range(16, 1)));
        run_phase(60, 28, 28);
        write_reg(CFG_BETA, 16'd3435);
        write_reg(CFG_OFFSET, 16'd0);
        run_phase(90, 0, 0);

        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

// ===== filelist.f =====
sv/ntc_pkg.sv
sv/ntc_div_cell.sv
sv/ntc_div_chain.sv
sv/ntc_horner_cell.sv
sv/ntc_adc_to_temperature.sv
bench/tb_ntc_adc_to_temperature.sv
